@@ hdl/assert_macros.svh @@
// Assertion macros used by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside of reset.
`define ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never occurs outside of reset.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_HOLDS(label, !(expr), msg)

`endif

@@ hdl/cfir_pkg.sv @@
// Package with constants, types and the rounding function of the complex FIR filter.
package cfir_pkg;

  localparam int MAX_TAPS    = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;

  localparam int DATA_W      = 16;
  localparam int TAP_INDEX_W = 5;
  localparam int TAP_COUNT_W = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 6;

  localparam int IDX_W  = $clog2(MAX_TAPS);
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int EXT_W  = ((IDX_W > TAP_INDEX_W) ? IDX_W : TAP_INDEX_W) + 1;
  localparam int LEVELS = $clog2(MAX_TAPS);
  localparam int LEAVES = 1 << LEVELS;

  localparam int MUL_W  = SAMPLE_BITS + COEF_BITS;
  localparam int PROD_W = MUL_W + 1;
  localparam int ACC_W  = PROD_W + LEVELS;
  localparam int RND_W  = ACC_W + 1;

  localparam int SAT_HI    = (2 ** (SAMPLE_BITS - 1)) - 1;
  localparam int SAT_LO    = -(2 ** (SAMPLE_BITS - 1));
  localparam int RND_BIAS  = 2 ** (COEF_BITS - 2);
  localparam int RND_SHIFT = COEF_BITS - 1;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = TAP_COUNT_W'(32);

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TAP    = 1'b1
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TAP_COUNT = 1'b0,
    CFG_REAL_TAPS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic rotate;
    logic tap_we;
    logic active;
    logic real_taps;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          clip;
  } sat_t;

  function automatic sat_t round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [RND_W-1:0] r;
    sat_t                    res;
    r = (RND_W'(acc) + RND_W'(RND_BIAS)) >>> RND_SHIFT;
    priority if (r > RND_W'(SAT_HI)) begin
      res.value = SAMPLE_BITS'(SAT_HI);
      res.clip  = 1'b1;
    end else if (r < RND_W'(SAT_LO)) begin
      res.value = SAMPLE_BITS'(SAT_LO);
      res.clip  = 1'b1;
    end else begin
      res.value = r[SAMPLE_BITS-1:0];
      res.clip  = 1'b0;
    end
    return res;
  endfunction

endpackage

@@ hdl/cfir_cell.sv @@
// One filter cell: a window sample, a tap on the rotation ring and its complex product.
module cfir_cell (
  input  logic                                        clk,
  input  logic                                        rst,
  input  cfir_pkg::cell_ctl_t                         ctl,
  input  logic signed [cfir_pkg::SAMPLE_BITS-1:0]     x_right_re,
  input  logic signed [cfir_pkg::SAMPLE_BITS-1:0]     x_right_im,
  input  logic signed [cfir_pkg::COEF_BITS-1:0]       tap_in_re,
  input  logic signed [cfir_pkg::COEF_BITS-1:0]       tap_in_im,
  input  logic signed [cfir_pkg::COEF_BITS-1:0]       tap_right_re,
  input  logic signed [cfir_pkg::COEF_BITS-1:0]       tap_right_im,
  output logic signed [cfir_pkg::SAMPLE_BITS-1:0]     x_re,
  output logic signed [cfir_pkg::SAMPLE_BITS-1:0]     x_im,
  output logic signed [cfir_pkg::COEF_BITS-1:0]       tap_re,
  output logic signed [cfir_pkg::COEF_BITS-1:0]       tap_im,
  output logic signed [cfir_pkg::PROD_W-1:0]          prod_re,
  output logic signed [cfir_pkg::PROD_W-1:0]          prod_im
);

  logic signed [cfir_pkg::SAMPLE_BITS-1:0] x_next_re;
  logic signed [cfir_pkg::SAMPLE_BITS-1:0] x_next_im;
  logic signed [cfir_pkg::COEF_BITS-1:0]   ti;
  logic signed [cfir_pkg::MUL_W-1:0]       p_rr;
  logic signed [cfir_pkg::MUL_W-1:0]       p_ii;
  logic signed [cfir_pkg::MUL_W-1:0]       p_ri;
  logic signed [cfir_pkg::MUL_W-1:0]       p_ir;

  always_comb begin
    x_next_re = ctl.shift ? x_right_re : x_re;
    x_next_im = ctl.shift ? x_right_im : x_im;
    ti        = ctl.real_taps ? '0 : tap_im;
    p_rr      = cfir_pkg::MUL_W'(tap_re) * cfir_pkg::MUL_W'(x_next_re);
    p_ii      = cfir_pkg::MUL_W'(ti) * cfir_pkg::MUL_W'(x_next_im);
    p_ri      = cfir_pkg::MUL_W'(tap_re) * cfir_pkg::MUL_W'(x_next_im);
    p_ir      = cfir_pkg::MUL_W'(ti) * cfir_pkg::MUL_W'(x_next_re);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_re <= '0;
      x_im <= '0;
    end else if (ctl.shift) begin
      x_re <= x_right_re;
      x_im <= x_right_im;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tap_we) begin
      tap_re <= tap_in_re;
      tap_im <= tap_in_im;
    end else if (ctl.rotate) begin
      tap_re <= tap_right_re;
      tap_im <= tap_right_im;
    end
    if (ctl.load) begin
      prod_re <= ctl.active ?
                 cfir_pkg::PROD_W'(p_rr) - cfir_pkg::PROD_W'(p_ii) : '0;
      prod_im <= ctl.active ?
                 cfir_pkg::PROD_W'(p_ri) + cfir_pkg::PROD_W'(p_ir) : '0;
    end
  end

endmodule

@@ hdl/cfir_sum_tree.sv @@
// Registered adder tree that sums the cell products, one tree level per stage.
module cfir_sum_tree (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [cfir_pkg::PROD_W-1:0]    leaf_re [cfir_pkg::MAX_TAPS],
  input  logic signed [cfir_pkg::PROD_W-1:0]    leaf_im [cfir_pkg::MAX_TAPS],
  input  cfir_pkg::tag_t                        leaf_tag,
  input  logic                                  drain,
  output logic                                  take,
  output logic signed [cfir_pkg::ACC_W-1:0]     sum_re,
  output logic signed [cfir_pkg::ACC_W-1:0]     sum_im,
  output cfir_pkg::tag_t                        sum_tag
);

  logic signed [cfir_pkg::ACC_W-1:0] node_re [2*cfir_pkg::LEAVES-1];
  logic signed [cfir_pkg::ACC_W-1:0] node_im [2*cfir_pkg::LEAVES-1];
  cfir_pkg::tag_t                    tag [cfir_pkg::LEVELS+1];
  logic [cfir_pkg::LEVELS:1]         load;

  always_comb begin
    load[cfir_pkg::LEVELS] = !tag[cfir_pkg::LEVELS].valid || drain;
    for (int s = cfir_pkg::LEVELS - 1; s >= 1; s--) begin
      load[s] = !tag[s].valid || load[s+1];
    end
  end

  assign tag[0] = leaf_tag;

  for (genvar gs = 1; gs <= cfir_pkg::LEVELS; gs++) begin : g_tag
    always_ff @(posedge clk) begin
      if (rst) begin
        tag[gs] <= '0;
      end else if (load[gs]) begin
        tag[gs] <= tag[gs-1];
      end
    end
  end

  for (genvar gj = 0; gj < cfir_pkg::LEAVES; gj++) begin : g_leaf
    if (gj < cfir_pkg::MAX_TAPS) begin : g_used
      assign node_re[cfir_pkg::LEAVES-1+gj] = cfir_pkg::ACC_W'(leaf_re[gj]);
      assign node_im[cfir_pkg::LEAVES-1+gj] = cfir_pkg::ACC_W'(leaf_im[gj]);
    end else begin : g_pad
      assign node_re[cfir_pkg::LEAVES-1+gj] = '0;
      assign node_im[cfir_pkg::LEAVES-1+gj] = '0;
    end
  end

  for (genvar gd = 0; gd < cfir_pkg::LEVELS; gd++) begin : g_level
    for (genvar gn = 0; gn < (1 << gd); gn++) begin : g_node
      localparam int NI = (1 << gd) - 1 + gn;
      always_ff @(posedge clk) begin
        if (load[cfir_pkg::LEVELS-gd]) begin
          node_re[NI] <= node_re[2*NI+1] + node_re[2*NI+2];
          node_im[NI] <= node_im[2*NI+1] + node_im[2*NI+2];
        end
      end
    end
  end

  assign take    = load[1];
  assign sum_re  = node_re[0];
  assign sum_im  = node_im[0];
  assign sum_tag = tag[cfir_pkg::LEVELS];

endmodule

@@ hdl/complex_fir_filter_top.sv @@
// Top level of the streaming complex FIR filter.
// One input transaction is taken every clock cycle while the output is not stalled and the tap
// ring is aligned: a sample enters a window held in a row of 32 cells, each cell registers its
// complex product as the sample is taken, and a registered adder tree of 5 levels sums the
// products; a result passes the product registers, the 5 tree levels, then rounding into the
// output register. Tap writes give no result. The taps sit on a ring through the cells,
// aligned to the newest end of the window; after tap_count is written the ring turns one place
// per cycle, and input transactions are stalled until it is aligned again.
`include "assert_macros.svh"

module complex_fir_filter_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [cfir_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [cfir_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   kind,
  input  logic [cfir_pkg::TAP_INDEX_W-1:0]       tap_index,
  input  logic signed [cfir_pkg::DATA_W-1:0]     data_re,
  input  logic signed [cfir_pkg::DATA_W-1:0]     data_im,
  input  logic                                   last_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [cfir_pkg::DATA_W-1:0]     out_re,
  output logic signed [cfir_pkg::DATA_W-1:0]     out_im,
  output logic                                   last_out,
  output logic                                   clipped
);

  logic [cfir_pkg::TAP_COUNT_W-1:0] tap_count;
  logic                             real_taps;
  logic [cfir_pkg::IDX_W-1:0]       rot;
  logic [cfir_pkg::IDX_W-1:0]       rot_next;
  logic [cfir_pkg::IDX_W-1:0]       rot_target;
  logic [cfir_pkg::CNT_W-1:0]       tsat;
  logic                             rotating;

  logic                             load0;
  logic                             accept;
  logic                             sample;
  logic                             tap_wr;
  logic [cfir_pkg::EXT_W-1:0]       k_ext;
  logic [cfir_pkg::EXT_W-1:0]       rot_ext;
  logic [cfir_pkg::EXT_W-1:0]       cell_diff;
  logic [cfir_pkg::IDX_W-1:0]       cell_sel;
  logic                             tap_ok;

  logic signed [cfir_pkg::SAMPLE_BITS-1:0] smp_re;
  logic signed [cfir_pkg::SAMPLE_BITS-1:0] smp_im;
  logic signed [cfir_pkg::COEF_BITS-1:0]   coef_in_re;
  logic signed [cfir_pkg::COEF_BITS-1:0]   coef_in_im;

  cfir_pkg::cell_ctl_t                     cell_ctl   [cfir_pkg::MAX_TAPS];
  logic signed [cfir_pkg::SAMPLE_BITS-1:0] win_re     [cfir_pkg::MAX_TAPS];
  logic signed [cfir_pkg::SAMPLE_BITS-1:0] win_im     [cfir_pkg::MAX_TAPS];
  logic signed [cfir_pkg::SAMPLE_BITS-1:0] x_right_re [cfir_pkg::MAX_TAPS];
  logic signed [cfir_pkg::SAMPLE_BITS-1:0] x_right_im [cfir_pkg::MAX_TAPS];
  logic signed [cfir_pkg::COEF_BITS-1:0]   ring_re    [cfir_pkg::MAX_TAPS];
  logic signed [cfir_pkg::COEF_BITS-1:0]   ring_im    [cfir_pkg::MAX_TAPS];
  logic signed [cfir_pkg::PROD_W-1:0]      prod_re    [cfir_pkg::MAX_TAPS];
  logic signed [cfir_pkg::PROD_W-1:0]      prod_im    [cfir_pkg::MAX_TAPS];

  cfir_pkg::tag_t                          pv;
  logic                                    tree_take;
  logic signed [cfir_pkg::ACC_W-1:0]       sum_re;
  logic signed [cfir_pkg::ACC_W-1:0]       sum_im;
  cfir_pkg::tag_t                          tree_tag;
  logic                                    drain;
  cfir_pkg::sat_t                          sat_re;
  cfir_pkg::sat_t                          sat_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= cfir_pkg::TAP_COUNT_RESET;
      real_taps <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfir_pkg::cfg_reg_t'(cfg_index))
        cfir_pkg::CFG_TAP_COUNT: tap_count <= cfg_data[cfir_pkg::TAP_COUNT_W-1:0];
        cfir_pkg::CFG_REAL_TAPS: real_taps <= cfg_data[0];
      endcase
    end
  end

  always_comb begin
    tsat       = (tap_count > cfir_pkg::MAX_TAPS) ? cfir_pkg::CNT_W'(cfir_pkg::MAX_TAPS) :
                                                    cfir_pkg::CNT_W'(tap_count);
    rot_target = (tsat == cfir_pkg::CNT_W'(cfir_pkg::MAX_TAPS)) ? '0 :
                                                                  tsat[cfir_pkg::IDX_W-1:0];
    rotating   = (rot != rot_target);
    rot_next   = (rot == cfir_pkg::IDX_W'(cfir_pkg::MAX_TAPS - 1)) ? '0 : rot + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot <= '0;
    end else if (rotating) begin
      rot <= rot_next;
    end
  end

  always_comb begin
    load0     = !pv.valid || tree_take;
    in_stall  = rotating || !load0;
    accept    = in_valid && !in_stall;
    sample    = accept && (cfir_pkg::kind_t'(kind) == cfir_pkg::KIND_SAMPLE);
    tap_wr    = accept && (cfir_pkg::kind_t'(kind) == cfir_pkg::KIND_TAP);
    k_ext     = cfir_pkg::EXT_W'(tap_index);
    rot_ext   = cfir_pkg::EXT_W'(rot);
    cell_diff = (k_ext >= rot_ext) ? k_ext - rot_ext :
                                     k_ext + cfir_pkg::EXT_W'(cfir_pkg::MAX_TAPS) - rot_ext;
    cell_sel  = cell_diff[cfir_pkg::IDX_W-1:0];
    tap_ok    = (k_ext < cfir_pkg::EXT_W'(cfir_pkg::MAX_TAPS));
  end

  assign smp_re     = $signed(data_re[cfir_pkg::SAMPLE_BITS-1:0]);
  assign smp_im     = $signed(data_im[cfir_pkg::SAMPLE_BITS-1:0]);
  assign coef_in_re = $signed(data_re[cfir_pkg::COEF_BITS-1:0]);
  assign coef_in_im = $signed(data_im[cfir_pkg::COEF_BITS-1:0]);

  for (genvar gw = 0; gw < cfir_pkg::MAX_TAPS; gw++) begin : g_cell
    localparam int NB = (gw + 1) % cfir_pkg::MAX_TAPS;

    if (gw == cfir_pkg::MAX_TAPS - 1) begin : g_newest
      assign x_right_re[gw] = smp_re;
      assign x_right_im[gw] = smp_im;
    end else begin : g_inner
      assign x_right_re[gw] = win_re[gw+1];
      assign x_right_im[gw] = win_im[gw+1];
    end

    always_comb begin
      cell_ctl[gw].shift     = sample;
      cell_ctl[gw].load      = load0;
      cell_ctl[gw].rotate    = rotating;
      cell_ctl[gw].tap_we    = tap_wr && tap_ok && (cell_sel == cfir_pkg::IDX_W'(gw));
      cell_ctl[gw].active    = (tsat >= cfir_pkg::CNT_W'(cfir_pkg::MAX_TAPS - gw));
      cell_ctl[gw].real_taps = real_taps;
    end

    cfir_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (cell_ctl[gw]),
      .x_right_re   (x_right_re[gw]),
      .x_right_im   (x_right_im[gw]),
      .tap_in_re    (coef_in_re),
      .tap_in_im    (coef_in_im),
      .tap_right_re (ring_re[NB]),
      .tap_right_im (ring_im[NB]),
      .x_re         (win_re[gw]),
      .x_im         (win_im[gw]),
      .tap_re       (ring_re[gw]),
      .tap_im       (ring_im[gw]),
      .prod_re      (prod_re[gw]),
      .prod_im      (prod_im[gw])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (load0) begin
      pv.valid <= sample;
      pv.last  <= last_in;
    end
  end

  cfir_sum_tree u_tree (
    .clk      (clk),
    .rst      (rst),
    .leaf_re  (prod_re),
    .leaf_im  (prod_im),
    .leaf_tag (pv),
    .drain    (drain),
    .take     (tree_take),
    .sum_re   (sum_re),
    .sum_im   (sum_im),
    .sum_tag  (tree_tag)
  );

  always_comb begin
    drain  = !out_valid || !out_stall;
    sat_re = cfir_pkg::round_sat(sum_re);
    sat_im = cfir_pkg::round_sat(sum_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain) begin
      out_valid <= tree_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_re   <= cfir_pkg::DATA_W'(sat_re.value);
      out_im   <= cfir_pkg::DATA_W'(sat_im.value);
      last_out <= tree_tag.last;
      clipped  <= sat_re.clip || sat_im.clip;
    end
  end

  `ASSERT_HOLDS(a_rot_advances, rotating |=> (rot != $past(rot)), "tap ring did not turn")
  `ASSERT_HOLDS(a_prod_hold, (pv.valid && !load0) |=> (pv.valid && $stable(pv.last)),
                "product stage lost a transaction")
  `ASSERT_HOLDS(a_tree_hold, (tree_tag.valid && out_valid && out_stall) |=> tree_tag.valid,
                "tree result dropped while output blocked")
  `ASSERT_NEVER(a_clip_rail,
                out_valid && clipped &&
                (out_re != cfir_pkg::DATA_W'(cfir_pkg::SAT_HI)) &&
                (out_re != cfir_pkg::DATA_W'(cfir_pkg::SAT_LO)) &&
                (out_im != cfir_pkg::DATA_W'(cfir_pkg::SAT_HI)) &&
                (out_im != cfir_pkg::DATA_W'(cfir_pkg::SAT_LO)),
                "clip flag without a saturated part")

endmodule
